>>> hw/rtl/u16u8_pkg.sv
// Package with the shared types, constants and the UTF-8 encoder function.
`default_nettype none

package u16u8_pkg;

    localparam int JOB_BYTES   = 6;
    localparam int JOBQ_DEPTH  = 2;
    localparam int CP_W        = 21;

    localparam logic [5:0]  HIGH_SUR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SUR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [15:0] HIGH_SUR_LO  = 16'hD800;

    // One item's worth of UTF-8 bytes, first byte in slot 0.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      last;
    } job_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } enc_t;

    function automatic enc_t encode_cp(input logic [CP_W-1:0] cp);
        enc_t e;
        e = '0;
        if (cp < 21'h80) begin
            e.b[0] = cp[7:0];
            e.len  = 3'd1;
        end
        else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.len  = 3'd2;
        end
        else if (cp < SUPP_BASE) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.len  = 3'd3;
        end
        else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/u16u8_front.sv
// Front end: takes code units, pairs surrogates and builds the byte list of each item.
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] code_unit,
    input  wire logic        last_unit,
    input  wire logic        push,
    input  wire logic        q_full,
    output logic             full,
    output logic             wr_en,
    output job_t             wr_job
);

    logic       pending_reg, pending_next;
    logic [9:0] held_reg, held_next;
    logic       accept;
    logic       is_high, is_low;
    enc_t       enc_held, enc_unit, enc_pair;
    logic [CP_W-1:0] pair_cp;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign is_high = (code_unit[15:10] == HIGH_SUR_TAG);
    assign is_low  = (code_unit[15:10] == LOW_SUR_TAG);
    assign pair_cp = SUPP_BASE + {1'b0, held_reg, code_unit[9:0]};

    always_comb
    begin
        enc_held = encode_cp({5'd0, HIGH_SUR_LO | {6'd0, held_reg}});
        enc_unit = encode_cp({5'd0, code_unit});
        enc_pair = encode_cp(pair_cp);
        pending_next = pending_reg;
        held_next    = held_reg;
        wr_job       = '0;
        wr_job.last  = last_unit;

        if (pending_reg && is_low) begin
            for (int k = 0; k < 4; k++)
            begin
                wr_job.bytes[k] = enc_pair.b[k];
            end
            wr_job.count = enc_pair.len;
            pending_next = 1'b0;
        end
        else begin
            // A held high surrogate that finds no partner goes out first, ahead of any bytes of the new unit.
            if (pending_reg) begin
                for (int k = 0; k < 3; k++)
                begin
                    wr_job.bytes[k] = enc_held.b[k];
                end
                wr_job.count = 3'd3;
            end
            pending_next = 1'b0;
            if (is_high && !last_unit) begin
                pending_next = 1'b1;
                held_next    = code_unit[9:0];
            end
            else if (pending_reg) begin
                for (int k = 0; k < 3; k++)
                begin
                    wr_job.bytes[3 + k] = enc_unit.b[k];
                end
                wr_job.count = 3'd3 + enc_unit.len;
            end
            else begin
                for (int k = 0; k < 3; k++)
                begin
                    wr_job.bytes[k] = enc_unit.b[k];
                end
                wr_job.count = enc_unit.len;
            end
        end
    end

    assign wr_en = accept && (wr_job.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= 1'b0;
            held_reg    <= '0;
        end
        else if (accept) begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/u16u8_jobq.sv
// Short register queue of byte lists between the front and back ends.
`default_nettype none

module u16u8_jobq
    import u16u8_pkg::*;
#(
    parameter int DEPTH = JOBQ_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  job_t      wr_job,
    input  wire logic rd_en,
    output job_t      head,
    output logic      q_empty,
    output logic      q_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == FULL_CNT);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/u16u8_back.sv
// Back end: walks the byte list at the queue head into the output register, one byte a cycle while the receiver pops.
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  job_t      head,
    input  wire logic q_empty,
    output logic      rd_en,
    input  wire logic pop,
    output logic      empty,
    output logic [7:0] out_byte,
    output logic      run_last,
    output logic      string_end
);

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       run_last_reg, end_reg;
    logic       load, final_byte;

    // The output register refills whenever the queue has a job and the register is free or being taken this cycle.
    assign load       = !q_empty && (!valid_reg || pop);
    assign final_byte = (idx_reg == head.count - 3'd1);
    assign rd_en      = load && final_byte;

    assign empty      = !valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = run_last_reg;
    assign string_end = end_reg;

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg     <= head.bytes[idx_reg];
            run_last_reg <= final_byte;
            end_reg      <= final_byte && head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= final_byte ? 3'd0 : idx_reg + 3'd1;
            end
            else if (pop) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/utf16_to_utf8_transcoder_top.sv
// An item taken at the input is written into the job queue and then loaded into the output register.
// The output register gives one byte per cycle while the receiver pops it; a plain unit yields
// one to three bytes and a surrogate pair four.
// The front end accepts one unit per cycle while the job queue has room.
// Reset (rst_n low, asynchronous) empties the queue and output and drops any held surrogate.
`default_nettype none

module utf16_to_utf8_transcoder_top
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = JOBQ_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] code_unit,
    input  wire logic        last_unit,
    input  wire logic        push,
    output logic             full,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             string_end,
    output logic             empty,
    input  wire logic        pop
);

    job_t wr_job, head;
    logic wr_en, rd_en, q_empty, q_full;

    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .push      (push),
        .q_full    (q_full),
        .full      (full),
        .wr_en     (wr_en),
        .wr_job    (wr_job)
    );

    u16u8_jobq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_job  (wr_job),
        .rd_en   (rd_en),
        .head    (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

`default_nettype wire

>>> hw/rtl/u16u8_checker.sv
// Port-level checker for the transcoder, bound to the top level.
`default_nettype none

module u16u8_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic [7:0]  out_byte,
    input wire logic        run_last,
    input wire logic        string_end,
    input wire logic        empty,
    input wire logic        pop
);

    // Set when the next byte to be taken opens a new item's run.
    logic run_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_start_reg <= 1'b1;
        end
        else if (pop && !empty) begin
            run_start_reg <= run_last;
        end
    end

    a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && string_end |-> run_last)
        else $error("string end flagged on a byte that does not close its run");

    a_lead_first: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && run_start_reg |-> out_byte[7:6] != 2'b10)
        else $error("run opens with a continuation byte");

    a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_byte[7] |-> run_last)
        else $error("single byte character not at the end of its run");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_byte))
        else $error("waiting item changed or vanished");

endmodule

bind utf16_to_utf8_transcoder_top u16u8_checker u_checker (.*);

`default_nettype wire

>>> tb/tb_utf16_to_utf8_transcoder_top.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder top level.
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder_top;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] PLANE1     = 21'h10000;
    localparam int          RANDOM_UNITS = 96;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          TAIL_CYCLES  = 20;

    typedef struct {
        logic [7:0] value;
        logic       run_last;
        logic       string_end;
    } utf8_byte_t;

    // Tracks the surrogate state and the bytes the transcoder still owes us.
    class utf8_byte_tracker;
        bit         high_held;
        bit [9:0]   high_bits;
        utf8_byte_t owed[$];
        logic [7:0] run_bytes[$];
        int         fails;

        function void add_byte(logic [7:0] v);
            run_bytes = {run_bytes, v};
        endfunction

        function void put_code_point(logic [20:0] cp);
            if (cp < 21'h80) begin
                add_byte(cp[7:0]);
            end
            else if (cp < 21'h800) begin
                add_byte(8'hC0 | cp[10:6]);
                add_byte(8'h80 | cp[5:0]);
            end
            else if (cp < PLANE1) begin
                add_byte(8'hE0 | cp[15:12]);
                add_byte(8'h80 | cp[11:6]);
                add_byte(8'h80 | cp[5:0]);
            end
            else begin
                add_byte(8'hF0 | cp[20:18]);
                add_byte(8'h80 | cp[17:12]);
                add_byte(8'h80 | cp[11:6]);
                add_byte(8'h80 | cp[5:0]);
            end
        endfunction

        function void note_unit(logic [15:0] unit, logic last);
            bit         is_high;
            bit         is_low;
            bit         paired;
            utf8_byte_t b;
            is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
            is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
            paired  = 1'b0;
            run_bytes.delete();
            if (high_held) begin
                high_held = 1'b0;
                if (is_low) begin
                    put_code_point(PLANE1 + {high_bits, unit[9:0]});
                    paired = 1'b1;
                end
                else begin
                    put_code_point({5'd0, HIGH_FIRST | {6'd0, high_bits}});
                end
                high_bits = '0;
            end
            if (!paired) begin
                if (is_high && !last) begin
                    high_held = 1'b1;
                    high_bits = unit[9:0];
                end
                else begin
                    put_code_point({5'd0, unit});
                end
            end
            foreach (run_bytes[k]) begin
                b.value      = run_bytes[k];
                b.run_last   = (k == run_bytes.size() - 1);
                b.string_end = b.run_last && last;
                owed = {owed, b};
            end
        endfunction

        function void check_byte(logic [7:0] value, logic run_last, logic string_end);
            utf8_byte_t e;
            if (owed.size() == 0) begin
                $error("unexpected byte: out_byte actual %02h", value);
                fails++;
                return;
            end
            e = owed.pop_front();
            if (value !== e.value) begin
                $error("out_byte: expected %02h, actual %02h", e.value, value);
                fails++;
            end
            if (run_last !== e.run_last) begin
                $error("run_last: expected %0b, actual %0b", e.run_last, run_last);
                fails++;
            end
            if (string_end !== e.string_end) begin
                $error("string_end: expected %0b, actual %0b", e.string_end, string_end);
                fails++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [15:0] code_unit = '0;
    logic        last_unit = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        string_end;
    logic        empty;

    utf8_byte_tracker tracker = new();

    bit hold_req = 1'b0;
    bit steady = 1'b0;
    int burst_left = 0;
    int units_sent = 0;

    utf16_to_utf8_transcoder_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_unit  (code_unit),
        .last_unit  (last_unit),
        .push       (push),
        .full       (full),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end),
        .empty      (empty),
        .pop        (pop)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both handshakes are sampled with the values that held just before the edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                tracker.note_unit(code_unit, last_unit);
            if (pop && !empty)
                tracker.check_byte(out_byte, run_last, string_end);
        end
    end

    // Receiver: switches between random stall patterns, and holds off
    // completely for a long stretch when asked to.
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(10, 40);
                end
                left--;
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 1) == 1);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_unit(input logic [15:0] unit, input logic last);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        push      <= 1'b1;
        code_unit <= unit;
        last_unit <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        units_sent++;
    endtask

    task automatic send_random_string();
        int len;
        int kind;
        bit last;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            // Now and then the end-of-string flag is scrambled.
            if ($urandom_range(0, 9) == 0)
                last = $urandom_range(0, 1);
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: send_unit(16'($urandom_range(0, 16'h007F)), last);
                3: send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
                4: begin
                    if ($urandom_range(0, 1) == 1)
                        send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), last);
                    else
                        send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last);
                end
                5, 6: begin
                    send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), 1'b0);
                    send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), last);
                end
                7: send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), last);
                8: send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), last);
                default: send_unit(16'($urandom()), last);
            endcase
        end
    endtask

    initial
    begin
        int start_count;
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Boundaries of the one-, two- and three-byte encodings.
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Proper surrogate pairs, lowest and highest.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Lone low surrogates.
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Held high followed by a plain unit, then by another high.
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hD801, 1'b0);
        send_unit(16'hDC12, 1'b1);
        // A high surrogate ending the string is flushed at once.
        send_unit(16'hD83D, 1'b1);
        // A held high followed by a last plain unit gives six bytes.
        send_unit(16'hDA55, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // A held high followed by a high that ends the string.
        send_unit(16'hD9AA, 1'b0);
        send_unit(16'hDB55, 1'b1);

        start_count = units_sent;
        while (units_sent - start_count < RANDOM_UNITS) begin
            send_random_string();
            if (!hold_done && units_sent - start_count >= 40) begin
                // Keep offering items back to back while the receiver holds off.
                hold_req = 1'b1;
                steady = 1'b1;
                repeat (4) send_random_string();
                steady = 1'b0;
                hold_done = 1'b1;
            end
            if (!drain_done && units_sent - start_count >= 80) begin
                push <= 1'b0;
                while (tracker.pending() != 0) @(posedge clk);
                @(posedge clk);
                drain_done = 1'b1;
            end
        end
        // Close the string so that nothing is left held.
        send_unit(16'h0041, 1'b1);
        push <= 1'b0;

        while (tracker.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
